/* sv/tcb_pkg.sv */
// ---------------------------------------------------------------------------
// tcb_pkg: shared types and constants for the text console buffer
// Character type, control codes and the sequencer state encoding.
// ---------------------------------------------------------------------------
package tcb_pkg;

    localparam int CHAR_W = 7;

    typedef logic [CHAR_W-1:0] char_t;

    localparam logic [7:0] CODE_BS    = 8'h08;
    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_LOW   = 8'd32;
    localparam logic [7:0] CODE_END   = 8'd127;
    localparam char_t      CHAR_SPACE = 7'h20;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_SCROLL = 4'b1000
    } tcb_state_t;

endpackage

/* sv/text_console_buffer_top.sv */
// ---------------------------------------------------------------------------
// text_console_buffer_top: ROWS x COLS text console with cursor
// Character store in one RAM, cursor and scroll offset in registers.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; each word gives exactly
// one result, shown for one cycle with done high. The receiver cannot stall:
// done is a plain strobe. After reset the block first blanks the whole store,
// one cell per cycle, with busy high until the last cell is written. A put
// that does not scroll gives its result in the next cycle, and the next word
// may enter at once. A read passes the registered RAM read port and then the
// ST_READ state, where the read result register loads. A put that scrolls
// (line feed on the last row, or a printable code wrapping off a full last
// row) sweeps the new bottom row through the single write port in ST_SCROLL.
// Scrolling rotates a top-row offset over the ring of rows, so no row is ever copied.
// ---------------------------------------------------------------------------
module text_console_buffer_top #(
    parameter int COLS = 40,
    parameter int ROWS = 26
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [7:0]           char_code,
    input  logic [4:0]           read_row,
    input  logic [5:0]           read_col,
    output logic                 done,
    output logic                 cell_changed,
    output logic [4:0]           changed_row,
    output logic [5:0]           changed_col,
    output tcb_pkg::char_t       changed_char,
    output logic                 scrolled,
    output logic [4:0]           cursor_row_out,
    output logic [5:0]           cursor_col_out,
    output tcb_pkg::char_t       read_char
);
    import tcb_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int RW1   = RW + 1;
    // column register also holds COLS, the "row full" mark
    localparam int CW    = $clog2(COLS + 1);

    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [RW:0]   ROWS_X    = RW1'(ROWS);
    localparam logic [CW-1:0] COLS_C    = CW'(COLS);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // screen row to physical row of the ring
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                               input logic [RW-1:0] t);
        logic [RW:0] s;
        s = {1'b0, r} + {1'b0, t};
        if (s >= ROWS_X)
        begin
            s = s - ROWS_X;
        end
        return s[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] pr,
                                                input logic [CW-1:0] c);
        return AW'(pr) * AW'(COLS) + AW'(c);
    endfunction

    // ---------------- state ----------------
    tcb_state_t        state_reg, state_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     top_reg, top_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [CW-1:0]     sweep_reg, sweep_next;
    logic [AW-1:0]     base_reg, base_next;
    char_t             fill_reg, fill_next;
    logic              range_reg, range_next;
    logic              done_reg, done_next;

    // result payload registers
    logic              chg_o_reg;
    logic [4:0]        crow_o_reg;
    logic [5:0]        ccol_o_reg;
    char_t             cchar_o_reg;
    logic              scr_o_reg;
    logic [4:0]        rrow_o_reg;
    logic [5:0]        rcol_o_reg;
    char_t             rchar_o_reg;

    // ---------------- put decode ----------------
    logic              last_row;
    logic [RW-1:0]     p_row;
    logic [CW-1:0]     p_col;
    logic [RW-1:0]     w_row;
    logic [CW-1:0]     w_col;
    logic              w_chg;
    logic              w_scr;
    char_t             w_char;

    always_comb
    begin
        last_row = (row_reg == LAST_ROW);
        p_row    = row_reg;
        p_col    = col_reg;
        w_row    = row_reg;
        w_col    = col_reg;
        w_chg    = 1'b0;
        w_scr    = 1'b0;
        w_char   = CHAR_SPACE;
        if (char_code == CODE_CR)
        begin
            p_col = '0;
        end
        else if (char_code == CODE_LF)
        begin
            p_col = '0;
            if (!last_row)
            begin
                p_row = row_reg + 1'b1;
            end
            else
            begin
                w_scr = 1'b1;
            end
        end
        else if (char_code == CODE_BS)
        begin
            if (col_reg != '0)
            begin
                p_col = col_reg - 1'b1;
                w_col = col_reg - 1'b1;
                w_chg = 1'b1;
            end
            else if (row_reg != '0)
            begin
                p_row = row_reg - 1'b1;
                p_col = LAST_COL;
                w_row = row_reg - 1'b1;
                w_col = LAST_COL;
                w_chg = 1'b1;
            end
        end
        else if (char_code >= CODE_LOW && char_code < CODE_END)
        begin
            w_chg  = 1'b1;
            w_char = char_code[CHAR_W-1:0];
            if (col_reg == COLS_C)
            begin
                // wrap first; on the last row this scrolls
                if (!last_row)
                begin
                    w_row = row_reg + 1'b1;
                    p_row = row_reg + 1'b1;
                end
                else
                begin
                    w_scr = 1'b1;
                end
                w_col = '0;
                p_col = CW'(1);
            end
            else
            begin
                w_col = col_reg;
                p_col = col_reg + 1'b1;
            end
        end
    end

    // ---------------- read decode ----------------
    logic              rd_in_range;
    logic [AW-1:0]     rd_addr;

    assign rd_in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLS);
    assign rd_addr     = rd_in_range
                       ? cell_addr(phys_row(RW'(read_row), top_reg), CW'(read_col))
                       : '0;

    // ---------------- RAM ports ----------------
    logic              accept;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    char_t             ram_wdata;
    logic              ram_re;
    char_t             ram_rdata;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign ram_re = accept && (kind == KIND_READ);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = CHAR_SPACE;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            ST_SCROLL:
            begin
                // column 0 of the new bottom row may carry the wrapped char
                ram_we    = 1'b1;
                ram_waddr = base_reg + AW'(sweep_reg);
                ram_wdata = (sweep_reg == '0) ? fill_reg : CHAR_SPACE;
            end
            ST_IDLE:
            begin
                if (accept && kind == KIND_PUT && w_chg && !w_scr)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(phys_row(w_row, top_reg), w_col);
                    ram_wdata = w_char;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcb_char_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        top_next   = top_reg;
        clr_next   = clr_reg;
        sweep_next = sweep_reg;
        base_next  = base_reg;
        fill_next  = fill_reg;
        range_next = range_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_READ)
                    begin
                        range_next = rd_in_range;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        row_next = p_row;
                        col_next = p_col;
                        if (w_scr)
                        begin
                            // new bottom row is the old top physical row
                            top_next   = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                            base_next  = cell_addr(top_reg, '0);
                            sweep_next = '0;
                            fill_next  = w_char;
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_COL)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            row_reg   <= '0;
            col_reg   <= '0;
            top_reg   <= '0;
            clr_reg   <= '0;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            top_reg   <= top_next;
            clr_reg   <= clr_next;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        fill_reg  <= fill_next;
        range_reg <= range_next;
    end

    // result payload: put results load on accept, read data while in ST_READ
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (kind == KIND_READ)
            begin
                chg_o_reg   <= 1'b0;
                crow_o_reg  <= '0;
                ccol_o_reg  <= '0;
                cchar_o_reg <= '0;
                scr_o_reg   <= 1'b0;
                rrow_o_reg  <= 5'(row_reg);
                rcol_o_reg  <= 6'(col_reg);
            end
            else
            begin
                chg_o_reg   <= w_chg;
                crow_o_reg  <= w_chg ? 5'(w_row) : '0;
                ccol_o_reg  <= w_chg ? 6'(w_col) : '0;
                cchar_o_reg <= w_chg ? w_char : '0;
                scr_o_reg   <= w_scr;
                rrow_o_reg  <= 5'(p_row);
                rcol_o_reg  <= 6'(p_col);
                rchar_o_reg <= '0;
            end
        end
        else if (state_reg == ST_READ)
        begin
            rchar_o_reg <= range_reg ? ram_rdata : CHAR_SPACE;
        end
    end

    assign done           = done_reg;
    assign cell_changed   = chg_o_reg;
    assign changed_row    = crow_o_reg;
    assign changed_col    = ccol_o_reg;
    assign changed_char   = cchar_o_reg;
    assign scrolled       = scr_o_reg;
    assign cursor_row_out = rrow_o_reg;
    assign cursor_col_out = rcol_o_reg;
    assign read_char      = rchar_o_reg;

endmodule

/* sv/tcb_char_ram.sv */
// ---------------------------------------------------------------------------
// tcb_char_ram: character store
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tcb_char_ram #(
    parameter int DEPTH = 1040,
    parameter int AW    = 11
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  tcb_pkg::char_t  wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output tcb_pkg::char_t  rdata
);
    import tcb_pkg::*;

    char_t mem [DEPTH];
    char_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
